### hdl/joint_rate_accel_limiter_top_defines.svh
// Assertion macros shared by the limiter's checker.
`ifndef JOINT_RATE_ACCEL_LIMITER_TOP_DEFINES_SVH
`define JOINT_RATE_ACCEL_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define JRAL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("limiter check failed");

// Next-cycle implication.
`define JRAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("limiter check failed");

`endif

### hdl/jral_pkg.sv
// Package of the joint rate limiter: field widths, codes and fixed constants.
package jral_pkg;

    localparam int POS_W   = 32;
    localparam int LIM_W   = 31;
    localparam int TIME_W  = 48;
    localparam int STEP_W  = 20;
    localparam int JIDX_W  = 3;
    localparam int FUNC_W  = 2;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_APPLY = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEED  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;   // unused code, echoed

    // register indexes (paddr[2])
    localparam logic REG_CLAMP = 1'b0;
    localparam logic REG_GUARD = 1'b1;

    localparam logic [STEP_W-1:0] STEP_MAX    = 20'hFFFFF;
    localparam logic [STEP_W-1:0] GUARD_RESET = 20'd1000;
    localparam logic [31:0]       USEC        = 32'd1000000;
    localparam logic [LIM_W-1:0]  MASK31      = 31'h7FFFFFFF;

endpackage

### hdl/jral_if.sv
// Handshake interfaces for the limiter's input and result channels.
interface jral_in_if import jral_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [TIME_W-1:0]        now_us;
    logic [JIDX_W-1:0]        joint_index;
    logic signed [POS_W-1:0]  target_position;
    logic [LIM_W-1:0]         vel_cap;
    logic [LIM_W-1:0]         acc_cap;
    logic signed [POS_W-1:0]  lower_bound;
    logic signed [POS_W-1:0]  upper_bound;

    modport source (output valid, func, now_us, joint_index, target_position,
                    vel_cap, acc_cap, lower_bound, upper_bound,
                    input ready);
    modport sink (input valid, func, now_us, joint_index, target_position,
                  vel_cap, acc_cap, lower_bound, upper_bound,
                  output ready);
endinterface

interface jral_out_if import jral_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [JIDX_W-1:0]        out_joint;
    logic signed [POS_W-1:0]  limited_position;
    logic signed [POS_W-1:0]  emitted_velocity;
    logic                     last_joint;
    logic                     was_limited;

    modport source (output valid, out_joint, limited_position, emitted_velocity,
                    last_joint, was_limited, input ready);
    modport sink (input valid, out_joint, limited_position, emitted_velocity,
                  last_joint, was_limited, output ready);
endinterface

### hdl/joint_rate_accel_limiter_top.sv
// Joint rate and acceleration limiter, top level.
// Use: joint items enter on i_in (valid/ready), one result per item leaves on o_out.
// func selects apply (limit target), seed (latch position) or load (joint limits).
// Joints of one control cycle come in order 0..JOINTS-1 with one timestamp; joint 0
// sets the step for the cycle. Registers clamp_enable and step_guard_us sit on an
// APB-style port (0x0, 0x4); the user must write them only while the block is idle,
// which the block itself does not enforce. Seed, load, echo and unseeded items
// register their result at acceptance and show it in the cycle after. A limited apply
// item goes through a bit-serial datapath: one shared shift-add multiplier, one
// restoring divider and, with an acceleration limit, a two-bits-a-cycle square root.
// Throughput: one item at a time; the next item is taken only in the idle state and
// only while the output register is empty or its result is being taken.
// Reset (synchronous, active low): unseeded, limits disabled, windows fully open,
// step 1000 us, output empty.
// Stall: a held result blocks acceptance of the next item and the loading of the next
// result; the block waits in its last step until the output register is free.
module joint_rate_accel_limiter_top import jral_pkg::*; #(
    parameter int JOINTS = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jral_in_if.sink           i_in,
    jral_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_D, ST_DIV_D, ST_MUL_AD, ST_SQRT, ST_MUL_AS, ST_DIV_AS,
        ST_MUL_MOVE, ST_DIV_MOVE, ST_POS, ST_DIFF, ST_MUL_EV, ST_DIV_EV, ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic              r_clamp_en;
    logic [STEP_W-1:0] r_guard;

    // cycle state and per-joint tables
    logic              r_seeded;
    logic [TIME_W-1:0] r_last_time;
    logic [STEP_W-1:0] r_cycle_step;
    logic signed [POS_W-1:0] r_held_pos [JOINTS];
    logic signed [POS_W-1:0] r_held_spd [JOINTS];
    logic [LIM_W-1:0]        r_vlim [JOINTS];
    logic [LIM_W-1:0]        r_alim [JOINTS];
    logic signed [POS_W-1:0] r_win_lo [JOINTS];
    logic signed [POS_W-1:0] r_win_hi [JOINTS];

    // working registers of one apply item
    logic [JIDX_W-1:0]       r_j;
    logic signed [POS_W-1:0] r_held;
    logic                    r_neg;
    logic [31:0]             r_dist;
    logic [STEP_W-1:0]       r_s;
    logic [LIM_W-1:0]        r_vmax;
    logic [LIM_W-1:0]        r_amax;
    logic [LIM_W-1:0]        r_hs_abs;
    logic [LIM_W-1:0]        r_spd;
    logic [40:0]             r_mag;
    logic signed [POS_W-1:0] r_np;
    logic                    r_diff_neg;
    logic [5:0]              r_cnt;

    // serial multiplier
    logic [63:0] r_ma;
    logic [31:0] r_mb;
    logic [63:0] r_acc;
    // serial divider
    logic [63:0] r_num;
    logic [27:0] r_rem;
    logic [27:0] r_dvs;
    // serial square root
    logic [55:0] r_rad;
    logic [27:0] r_root;
    logic [29:0] r_srem;

    // output register
    logic                    r_ovalid;
    logic [JIDX_W-1:0]       r_ojoint;
    logic signed [POS_W-1:0] r_opos;
    logic signed [POS_W-1:0] r_ovel;
    logic                    r_olast;
    logic                    r_olim;

    // combinational
    logic              accept;
    logic              in_range;
    logic [JW-1:0]     jidx_in;
    logic [JW-1:0]     jidx;
    logic [TIME_W-1:0] tdiff;
    logic [STEP_W-1:0] n_step;
    logic [STEP_W-1:0] n_s;
    logic signed [POS_W-1:0] in_held;
    logic signed [32:0]      delta;
    logic [32:0]             ndelta;
    logic [31:0]             n_dist;
    logic signed [POS_W-1:0] in_hs;
    logic signed [POS_W-1:0] neg_hs;
    logic [63:0] mul_sum;
    logic [28:0] div_trial;
    logic        div_ge;
    logic [27:0] div_rem_n;
    logic [63:0] div_num_n;
    logic [31:0] sq_t;
    logic [31:0] sq_trial;
    logic        sq_ge;
    logic [27:0] sq_root_n;
    logic [LIM_W-1:0] spd_d;
    logic [32:0]      a_term;
    logic [LIM_W-1:0] spd_a;
    logic [LIM_W-1:0] spd_r;
    logic signed [41:0]      pos_sum;
    logic signed [POS_W-1:0] pos_sat;
    logic signed [POS_W-1:0] pos_clamp;
    logic signed [32:0]      diff33;
    logic [32:0]             ndiff;
    logic [31:0]             diff_mag;
    logic signed [POS_W-1:0] evel;
    logic                    out_free;
    logic                    last_in;

    assign out_free   = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in.valid && i_in.ready;

    assign in_range = ({29'd0, i_in.joint_index} < 32'(JOINTS));
    assign last_in  = ({29'd0, i_in.joint_index} == 32'(JOINTS - 1));
    assign jidx_in  = JW'(i_in.joint_index);
    assign jidx     = JW'(r_j);

    // step of the cycle, worked out on joint 0
    always_comb begin
        tdiff = i_in.now_us - r_last_time;
        if (i_in.now_us > r_last_time) begin
            n_step = (tdiff > {28'd0, STEP_MAX}) ? STEP_MAX : tdiff[STEP_W-1:0];
        end else begin
            n_step = (r_guard == '0) ? STEP_W'(1) : r_guard;
        end
        n_s = (i_in.joint_index == '0) ? n_step : r_cycle_step;
    end

    assign in_held = r_held_pos[jidx_in];
    assign delta   = {i_in.target_position[31], i_in.target_position} - {in_held[31], in_held};
    assign ndelta  = -delta;
    assign n_dist  = delta[32] ? ndelta[31:0] : delta[31:0];
    assign in_hs   = r_held_spd[jidx_in];
    assign neg_hs  = -in_hs;

    // one bit of each serial unit per cycle
    assign mul_sum   = r_acc + (r_mb[0] ? r_ma : 64'd0);
    assign div_trial = {r_rem, r_num[63]};
    assign div_ge    = (div_trial >= {1'b0, r_dvs});
    assign div_rem_n = div_ge ? 28'(div_trial - {1'b0, r_dvs}) : div_trial[27:0];
    assign div_num_n = {r_num[62:0], div_ge};
    assign sq_t      = {r_srem, r_rad[55:54]};
    assign sq_trial  = {2'b00, r_root, 2'b01};
    assign sq_ge     = (sq_t >= sq_trial);
    assign sq_root_n = {r_root[26:0], sq_ge};

    // speed candidates
    always_comb begin
        spd_d = (|div_num_n[63:31]) ? MASK31 : div_num_n[30:0];
        if ((r_vmax != '0) && (spd_d > r_vmax)) begin
            spd_d = r_vmax;
        end
        a_term = {2'b00, r_hs_abs} +
                 ((|div_num_n[63:32]) ? 33'h0FFFFFFFF : {1'b0, div_num_n[31:0]});
        spd_a  = ({2'b00, r_spd} > a_term) ? a_term[30:0] : r_spd;
        spd_r  = ({3'b000, sq_root_n} < r_spd) ? sq_root_n[27:0] : r_spd;
    end

    // new position: saturate, then window clamp if clamp_enable is set
    always_comb begin
        pos_sum = {{10{r_held[31]}}, r_held} +
                  (r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag}));
        if (pos_sum > 42'sh0007FFFFFFF) begin
            pos_sat = 32'sh7FFFFFFF;
        end else if (pos_sum < -42'sh00080000000) begin
            pos_sat = 32'sh80000000;
        end else begin
            pos_sat = pos_sum[31:0];
        end
        pos_clamp = pos_sat;
        if (r_clamp_en) begin
            if (pos_sat < r_win_lo[jidx]) begin
                pos_clamp = r_win_lo[jidx];
            end else if (pos_sat > r_win_hi[jidx]) begin
                pos_clamp = r_win_hi[jidx];
            end
        end
    end

    assign diff33   = {r_np[31], r_np} - {r_held[31], r_held};
    assign ndiff    = -diff33;
    assign diff_mag = diff33[32] ? ndiff[31:0] : diff33[31:0];

    always_comb begin
        if (r_diff_neg) begin
            evel = (div_num_n > 64'h80000000) ? 32'sh80000000 : -$signed(div_num_n[31:0]);
        end else begin
            evel = (div_num_n > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(div_num_n[31:0]);
        end
    end

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GUARD) ? {12'd0, r_guard} : {31'd0, r_clamp_en};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_en <= 1'b0;
            r_guard    <= GUARD_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_GUARD) begin
                r_guard <= pwdata[STEP_W-1:0];
            end else begin
                r_clamp_en <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seeded     <= 1'b0;
            r_last_time  <= '0;
            r_cycle_step <= GUARD_RESET;
            r_ovalid     <= 1'b0;
            for (int k = 0; k < JOINTS; k++) begin
                r_held_pos[k] <= '0;
                r_held_spd[k] <= '0;
                r_vlim[k]     <= '0;
                r_alim[k]     <= '0;
                r_win_lo[k]   <= 32'sh80000000;
                r_win_hi[k]   <= 32'sh7FFFFFFF;
            end
        end else begin
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            // serial units step every cycle; unused ones idle harmlessly
            r_acc <= mul_sum;
            r_ma  <= {r_ma[62:0], 1'b0};
            r_mb  <= {1'b0, r_mb[31:1]};
            r_num <= div_num_n;
            r_rem <= div_rem_n;
            r_srem <= sq_ge ? 30'(sq_t - sq_trial) : sq_t[29:0];
            r_root <= sq_root_n;
            r_rad  <= {r_rad[53:0], 2'b00};
            r_cnt  <= r_cnt - 6'd1;

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        // echo result unless this is a limited apply
                        r_ovalid <= 1'b1;
                        r_ojoint <= i_in.joint_index;
                        r_opos   <= i_in.target_position;
                        r_ovel   <= '0;
                        r_olast  <= last_in;
                        r_olim   <= 1'b0;
                        if (in_range) begin
                            if (i_in.func == FUNC_SEED) begin
                                r_held_pos[jidx_in] <= i_in.target_position;
                                r_held_spd[jidx_in] <= '0;
                                r_last_time <= i_in.now_us;
                                r_seeded    <= 1'b1;
                            end else if (i_in.func == FUNC_LOAD) begin
                                r_vlim[jidx_in]   <= i_in.vel_cap;
                                r_alim[jidx_in]   <= i_in.acc_cap;
                                r_win_lo[jidx_in] <= i_in.lower_bound;
                                r_win_hi[jidx_in] <= i_in.upper_bound;
                            end else if ((i_in.func == FUNC_APPLY) && r_seeded) begin
                                r_ovalid <= 1'b0;
                                if (i_in.joint_index == '0) begin
                                    r_last_time  <= i_in.now_us;
                                    r_cycle_step <= n_step;
                                end
                                r_j      <= i_in.joint_index;
                                r_held   <= in_held;
                                r_neg    <= delta[32];
                                r_dist   <= n_dist;
                                r_s      <= n_s;
                                r_dvs    <= {n_s, 8'd0};
                                r_vmax   <= r_vlim[jidx_in];
                                r_amax   <= r_alim[jidx_in];
                                r_hs_abs <= in_hs[31] ? neg_hs[30:0] : in_hs[30:0];
                                // distance * 1e6
                                r_ma  <= {32'd0, n_dist};
                                r_mb  <= USEC;
                                r_acc <= '0;
                                r_cnt <= 6'd31;
                                r_state <= ST_MUL_D;
                            end
                        end
                    end
                end
                ST_MUL_D: begin
                    if (r_cnt == '0) begin
                        r_num <= mul_sum;
                        r_rem <= '0;
                        r_cnt <= 6'd63;
                        r_state <= ST_DIV_D;
                    end
                end
                ST_DIV_D: begin
                    if (r_cnt == '0) begin
                        r_spd <= spd_d;
                        r_acc <= '0;
                        r_cnt <= 6'd31;
                        if (r_amax != '0) begin
                            r_ma <= {33'd0, r_amax};
                            r_mb <= r_dist;
                            r_state <= ST_MUL_AD;
                        end else begin
                            r_ma <= {33'd0, spd_d};
                            r_mb <= {12'd0, r_s};
                            r_state <= ST_MUL_MOVE;
                        end
                    end
                end
                ST_MUL_AD: begin
                    if (r_cnt == '0) begin
                        r_rad  <= mul_sum[62:7];
                        r_srem <= '0;
                        r_root <= '0;
                        r_cnt  <= 6'd27;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_cnt == '0) begin
                        r_spd <= spd_r;
                        r_ma  <= {33'd0, r_amax};
                        r_mb  <= {12'd0, r_s};
                        r_acc <= '0;
                        r_cnt <= 6'd31;
                        r_state <= ST_MUL_AS;
                    end
                end
                ST_MUL_AS: begin
                    if (r_cnt == '0) begin
                        r_num <= mul_sum;
                        r_rem <= '0;
                        r_dvs <= USEC[27:0];
                        r_cnt <= 6'd63;
                        r_state <= ST_DIV_AS;
                    end
                end
                ST_DIV_AS: begin
                    if (r_cnt == '0) begin
                        r_spd <= spd_a;
                        r_ma  <= {33'd0, spd_a};
                        r_mb  <= {12'd0, r_s};
                        r_acc <= '0;
                        r_cnt <= 6'd31;
                        r_state <= ST_MUL_MOVE;
                    end
                end
                ST_MUL_MOVE: begin
                    if (r_cnt == '0) begin
                        // speed * step * 256 / 1e6
                        r_num <= {mul_sum[55:0], 8'd0};
                        r_rem <= '0;
                        r_dvs <= USEC[27:0];
                        r_cnt <= 6'd63;
                        r_state <= ST_DIV_MOVE;
                    end
                end
                ST_DIV_MOVE: begin
                    if (r_cnt == '0) begin
                        r_mag <= div_num_n[40:0];
                        r_state <= ST_POS;
                    end
                end
                ST_POS: begin
                    r_np <= pos_clamp;
                    // held speed is the pre-clamp speed
                    r_held_spd[jidx] <= r_neg ? -$signed({1'b0, r_spd}) : $signed({1'b0, r_spd});
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    r_diff_neg <= diff33[32];
                    r_ma  <= {32'd0, diff_mag};
                    r_mb  <= USEC;
                    r_acc <= '0;
                    r_cnt <= 6'd31;
                    r_state <= ST_MUL_EV;
                end
                ST_MUL_EV: begin
                    if (r_cnt == '0) begin
                        r_num <= mul_sum;
                        r_rem <= '0;
                        r_dvs <= {r_s, 8'd0};
                        r_cnt <= 6'd63;
                        r_state <= ST_DIV_EV;
                    end
                end
                ST_DIV_EV: begin
                    if (r_cnt == '0) begin
                        r_ovel  <= evel;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_held_pos[jidx] <= r_np;
                        r_ovalid <= 1'b1;
                        r_ojoint <= r_j;
                        r_opos   <= r_np;
                        r_olast  <= ({29'd0, r_j} == 32'(JOINTS - 1));
                        r_olim   <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.out_joint        = r_ojoint;
    assign o_out.limited_position = r_opos;
    assign o_out.emitted_velocity = r_ovel;
    assign o_out.last_joint       = r_olast;
    assign o_out.was_limited      = r_olim;

endmodule

### hdl/jral_checker.sv
// Port-level checker of the limiter and its bind to the top level.
`include "joint_rate_accel_limiter_top_defines.svh"

module jral_checker #(
    parameter int JOINTS = 7
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_joint,
    input logic        i_out_last,
    input logic        i_out_lim,
    input logic [31:0] i_out_vel
);

    // a waiting result is not withdrawn
    `JRAL_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    // last flag marks the final joint
    `JRAL_ASSERT_NOW(a_last_flag, i_out_valid, i_out_last == ({29'd0, i_out_joint} == 32'(JOINTS - 1)))
    // echoed items carry zero velocity
    `JRAL_ASSERT_NOW(a_echo_vel, i_out_valid && !i_out_lim, i_out_vel == 32'd0)

endmodule

bind joint_rate_accel_limiter_top jral_checker #(.JOINTS(JOINTS)) u_jral_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_joint (o_out.out_joint),
    .i_out_last  (o_out.last_joint),
    .i_out_lim   (o_out.was_limited),
    .i_out_vel   (o_out.emitted_velocity)
);
